>>> design/tsom_pkg.sv
// package for the three-stacks-in-one-memory block
// sizes, command, selector and status codes; no dependencies

package tsom_pkg;

    localparam int DEPTH     = 32;
    localparam int WORD_BITS = 32;
    localparam int HALF      = DEPTH / 2;

    // memory address and pointer widths
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PTR_A_W = $clog2(HALF + 1);
    localparam int PTR_B_W = ADDR_W;
    localparam int PTR_C_W = ADDR_W + 1;

    // fixed field widths of the stream items
    localparam int CMD_W    = 2;
    localparam int SEL_W    = 2;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int FLAGS_W  = 3;
    localparam int FREE_W   = 5;

    localparam int IN_USER_W  = CMD_W + SEL_W;
    localparam int IN_DATA_W  = VALUE_W;
    localparam int OUT_USER_W = STATUS_W;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [SEL_W-1:0] {
        SEL_A = 2'd0,
        SEL_B = 2'd1,
        SEL_C = 2'd2
    } sel_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // flag bit positions
    localparam int FLAG_A = 0;
    localparam int FLAG_B = 1;
    localparam int FLAG_C = 2;

    // output tdata bit positions
    localparam int POP_LSB   = 0;
    localparam int EMPTY_LSB = POP_LSB + VALUE_W;
    localparam int FULL_LSB  = EMPTY_LSB + FLAGS_W;
    localparam int FREE_LO_LSB = FULL_LSB + FLAGS_W;
    localparam int FREE_UP_LSB = FREE_LO_LSB + FREE_W;

endpackage

>>> design/three_stacks_one_memory.sv
// top level: three lifo stacks that share one synchronous word memory
// depends on tsom_pkg

// Three stacks live in one memory of tsom_pkg::DEPTH words. Stack A grows up
// from address 0 and is confined to the lower half; stack C grows up from the
// middle and stack B grows down from the top, so B and C share the upper half
// and are both full when they meet. Each input transfer carries a command and
// a stack selector in s_axis_tuser and the word to push in s_axis_tdata; each
// one yields exactly one output transfer with a status (ok, push rejected
// because full, pop rejected because empty), the popped word (zero unless a
// pop succeeded), empty and full flags of all three stacks after the step and
// the free slots left in each half. A rejected push or pop changes nothing.
// Selector 3 names no stack and command 3 acts as a query. The stack pointers
// sit in registers. The memory write (push) or read (pop) is issued at the
// input transfer and the result, with the registered read data, is shown
// in the next cycle. A new item is taken in every cycle as long as the output
// side takes results; the single output register holds a result until it is
// taken, which holds off the input. There is no clearing pass: a pop can only
// reach words that a push wrote.

module three_stacks_one_memory (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // push_value
    input  logic [tsom_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd [1:0], stack_sel [3:2]
    input  logic [tsom_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pop_value [31:0], empty_flags [34:32], full_flags [37:35],
    // free_lower [42:38], free_upper [47:43]
    output logic [tsom_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [tsom_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    localparam int ADDR_W  = tsom_pkg::ADDR_W;
    localparam int PTR_A_W = tsom_pkg::PTR_A_W;
    localparam int PTR_B_W = tsom_pkg::PTR_B_W;
    localparam int PTR_C_W = tsom_pkg::PTR_C_W;
    localparam int WORD_W  = tsom_pkg::WORD_BITS;
    localparam int FLAGS_W = tsom_pkg::FLAGS_W;
    localparam int FREE_W  = tsom_pkg::FREE_W;
    localparam int VALUE_W = tsom_pkg::VALUE_W;

    // shared word memory
    logic [WORD_W-1:0] mem [tsom_pkg::DEPTH];

    // stack pointers: next free slot of each stack
    logic [PTR_A_W-1:0] ptr_a_reg, ptr_a_next;
    logic [PTR_B_W-1:0] ptr_b_reg, ptr_b_next;
    logic [PTR_C_W-1:0] ptr_c_reg, ptr_c_next;

    // output register
    logic                    out_valid_reg;
    tsom_pkg::status_t       status_reg, status_next;
    logic                    pop_ok_reg;
    logic [FLAGS_W-1:0]      empty_reg, empty_next;
    logic [FLAGS_W-1:0]      full_reg, full_next;
    logic [FREE_W-1:0]       free_lo_reg, free_lo_next;
    logic [FREE_W-1:0]       free_up_reg, free_up_next;
    logic [WORD_W-1:0]       rd_data_reg;

    // decoded input transfer
    tsom_pkg::cmd_t          cmd;
    tsom_pkg::sel_t          sel;
    logic [WORD_W-1:0]       push_word;
    logic                    in_xfer;

    // memory access for this step
    logic                    wr_en, rd_en;
    logic [ADDR_W-1:0]       wr_addr, rd_addr;

    // state flags before the step
    logic                    a_empty, a_full, b_empty, c_empty, bc_full;
    logic [PTR_C_W-1:0]      ptr_b_ext, ptr_b_next_ext;

    assign cmd       = tsom_pkg::cmd_t'(s_axis_tuser[tsom_pkg::CMD_W-1:0]);
    assign sel       = tsom_pkg::sel_t'(s_axis_tuser[tsom_pkg::IN_USER_W-1:tsom_pkg::CMD_W]);
    assign push_word = s_axis_tdata[WORD_W-1:0];

    // one output register: take a new item when it is empty or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign ptr_b_ext = PTR_C_W'(ptr_b_reg);
    assign a_empty   = (ptr_a_reg == '0);
    assign a_full    = (ptr_a_reg == PTR_A_W'(tsom_pkg::HALF));
    assign b_empty   = (ptr_b_reg == PTR_B_W'(tsom_pkg::DEPTH - 1));
    assign c_empty   = (ptr_c_reg == PTR_C_W'(tsom_pkg::HALF));
    assign bc_full   = (ptr_c_reg == ptr_b_ext + PTR_C_W'(1));

    // step decode: pointer moves and the one memory access
    always_comb
    begin
        ptr_a_next  = ptr_a_reg;
        ptr_b_next  = ptr_b_reg;
        ptr_c_next  = ptr_c_reg;
        status_next = tsom_pkg::ST_OK;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = ADDR_W'(ptr_a_reg);
        rd_addr     = ADDR_W'(ptr_a_reg);
        unique case (cmd)
            tsom_pkg::CMD_PUSH:
            begin
                unique case (sel)
                    tsom_pkg::SEL_A:
                    begin
                        if (a_full)
                        begin
                            status_next = tsom_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = ADDR_W'(ptr_a_reg);
                            ptr_a_next = ptr_a_reg + PTR_A_W'(1);
                        end
                    end
                    tsom_pkg::SEL_B:
                    begin
                        if (bc_full)
                        begin
                            status_next = tsom_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = ADDR_W'(ptr_b_reg);
                            ptr_b_next = ptr_b_reg - PTR_B_W'(1);
                        end
                    end
                    tsom_pkg::SEL_C:
                    begin
                        if (bc_full)
                        begin
                            status_next = tsom_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = ADDR_W'(ptr_c_reg);
                            ptr_c_next = ptr_c_reg + PTR_C_W'(1);
                        end
                    end
                    default:
                    begin
                        // unused selector: nothing happens
                    end
                endcase
            end
            tsom_pkg::CMD_POP:
            begin
                unique case (sel)
                    tsom_pkg::SEL_A:
                    begin
                        if (a_empty)
                        begin
                            status_next = tsom_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            ptr_a_next = ptr_a_reg - PTR_A_W'(1);
                            rd_addr    = ADDR_W'(ptr_a_next);
                        end
                    end
                    tsom_pkg::SEL_B:
                    begin
                        if (b_empty)
                        begin
                            status_next = tsom_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            ptr_b_next = ptr_b_reg + PTR_B_W'(1);
                            rd_addr    = ADDR_W'(ptr_b_next);
                        end
                    end
                    tsom_pkg::SEL_C:
                    begin
                        if (c_empty)
                        begin
                            status_next = tsom_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            ptr_c_next = ptr_c_reg - PTR_C_W'(1);
                            rd_addr    = ADDR_W'(ptr_c_next);
                        end
                    end
                    default:
                    begin
                        // unused selector: nothing happens
                    end
                endcase
            end
            default:
            begin
                // query and the unused command leave the stacks alone
            end
        endcase
    end

    // flags and free counts after the step
    assign ptr_b_next_ext = PTR_C_W'(ptr_b_next);

    always_comb
    begin
        empty_next = '0;
        full_next  = '0;
        empty_next[tsom_pkg::FLAG_A] = (ptr_a_next == '0);
        empty_next[tsom_pkg::FLAG_B] = (ptr_b_next == PTR_B_W'(tsom_pkg::DEPTH - 1));
        empty_next[tsom_pkg::FLAG_C] = (ptr_c_next == PTR_C_W'(tsom_pkg::HALF));
        full_next[tsom_pkg::FLAG_A]  = (ptr_a_next == PTR_A_W'(tsom_pkg::HALF));
        full_next[tsom_pkg::FLAG_B]  = (ptr_c_next == ptr_b_next_ext + PTR_C_W'(1));
        full_next[tsom_pkg::FLAG_C]  = full_next[tsom_pkg::FLAG_B];
        free_lo_next = FREE_W'(PTR_C_W'(tsom_pkg::HALF) - PTR_C_W'(ptr_a_next));
        free_up_next = FREE_W'(ptr_b_next_ext + PTR_C_W'(1) - ptr_c_next);
    end

    // memory: one write or one registered read per step
    always_ff @(posedge clk)
    begin
        if (in_xfer && wr_en)
        begin
            mem[wr_addr] <= push_word;
        end
        if (in_xfer && rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // pointers and output handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_a_reg     <= '0;
            ptr_b_reg     <= PTR_B_W'(tsom_pkg::DEPTH - 1);
            ptr_c_reg     <= PTR_C_W'(tsom_pkg::HALF);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                ptr_a_reg     <= ptr_a_next;
                ptr_b_reg     <= ptr_b_next;
                ptr_c_reg     <= ptr_c_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each input transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            status_reg  <= status_next;
            pop_ok_reg  <= rd_en;
            empty_reg   <= empty_next;
            full_reg    <= full_next;
            free_lo_reg <= free_lo_next;
            free_up_reg <= free_up_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {free_up_reg, free_lo_reg, full_reg, empty_reg,
                            pop_ok_reg ? VALUE_W'(rd_data_reg) : VALUE_W'(0)};

endmodule

>>> design/tsom_checker.sv
// port-level checker for three_stacks_one_memory, with its bind
// depends on tsom_pkg and the top level's ports

module tsom_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tsom_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [tsom_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    // a stalled result transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // popped word is zero unless the step succeeded
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != tsom_pkg::ST_OK |->
            m_axis_tdata[tsom_pkg::EMPTY_LSB-1:tsom_pkg::POP_LSB] == '0)
        else $error("nonzero pop value on rejected step");

    // stack a never empty and full at once
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            !(m_axis_tdata[tsom_pkg::EMPTY_LSB + tsom_pkg::FLAG_A] &&
              m_axis_tdata[tsom_pkg::FULL_LSB + tsom_pkg::FLAG_A]))
        else $error("stack a empty and full");

    // b and c share one full condition
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata[tsom_pkg::FULL_LSB + tsom_pkg::FLAG_B] ==
            m_axis_tdata[tsom_pkg::FULL_LSB + tsom_pkg::FLAG_C])
        else $error("b and c full flags differ");

    // free counts never exceed a half
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata[tsom_pkg::FREE_UP_LSB-1:tsom_pkg::FREE_LO_LSB] <=
                tsom_pkg::FREE_W'(tsom_pkg::HALF) &&
            m_axis_tdata[tsom_pkg::FREE_UP_LSB+tsom_pkg::FREE_W-1:tsom_pkg::FREE_UP_LSB] <=
                tsom_pkg::FREE_W'(tsom_pkg::HALF))
        else $error("free count out of range");

endmodule

bind three_stacks_one_memory tsom_checker u_tsom_checker (.*);
